// File: src/pafl_pkg.sv
// shared types, constants and codes of the per-account flood limiter
package pafl_pkg;

  localparam int SLOTS  = 1024;
  localparam int SLOT_W = $clog2(SLOTS);

  localparam int ACCT_W = 10;
  localparam int SEC_W  = 32;
  localparam int FRAC_W = 10;
  localparam int TIME_W = SEC_W + FRAC_W;
  localparam int TOK_W  = 24;
  localparam int FRACT_TOK_W = 16;
  localparam int EL_W   = TOK_W;
  localparam int RATE_W = 16;
  localparam int PROD_W = EL_W + RATE_W;
  localparam int DROP_W = 8;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BURST  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFILL = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DROPS  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE   = 4'd3;

  localparam logic [7:0]  BURST_RST  = 8'd5;
  localparam logic [15:0] REFILL_RST = 16'd64;
  localparam logic [7:0]  DROPS_RST  = 8'd5;
  localparam logic [15:0] MUTE_RST   = 16'd60;

  typedef enum logic [1:0] {
    V_ALLOW = 2'd0,
    V_DROP  = 2'd1,
    V_MUTE  = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_MUL,
    ST_UPD
  } state_t;

  typedef struct packed {
    logic                seen;
    logic [TIME_W-1:0]   last_time;
    logic [TOK_W-1:0]    tokens;
    logic [DROP_W-1:0]   drop_run;
    logic [SEC_W-1:0]    deadline;
  } entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    entry_t            wr_data;
  } store_req_t;

endpackage

// File: src/pafl_ifs.sv
// handshake channel interfaces of the flood limiter
interface pafl_in_if;
  logic        valid;
  logic        ready;
  logic [9:0]  account_slot;
  logic [31:0] now_seconds;
  logic [9:0]  now_fraction;
  modport source (output valid, account_slot, now_seconds, now_fraction, input ready);
  modport sink (input valid, account_slot, now_seconds, now_fraction, output ready);
endinterface

interface pafl_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [31:0] mute_until;
  modport source (output valid, verdict, mute_until, input ready);
  modport sink (input valid, verdict, mute_until, output ready);
endinterface

interface pafl_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: src/pafl_store.sv
// per-slot bucket memory with clearing sweep after reset
module pafl_store (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pafl_pkg::store_req_t req,
  output pafl_pkg::entry_t     rd_data,
  output logic                 busy
);

  pafl_pkg::entry_t mem [pafl_pkg::SLOTS];
  pafl_pkg::entry_t rd_data_r;

  logic                      busy_r;
  logic                      busy_nxt;
  logic [pafl_pkg::SLOT_W-1:0] clr_idx_r;
  logic [pafl_pkg::SLOT_W-1:0] clr_idx_nxt;

  always_comb begin
    busy_nxt    = busy_r;
    clr_idx_nxt = clr_idx_r;
    if (busy_r) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (clr_idx_r == pafl_pkg::SLOT_W'(pafl_pkg::SLOTS - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_idx_r <= '0;
    end else begin
      busy_r    <= busy_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = busy_r;

endmodule

// File: src/per_account_flood_limiter.sv
// top level: per-slot token bucket flood limiter
//
// channel | dir | payload                                  | accepted when
// in_if   | in  | account_slot, now_seconds, now_fraction  | valid && ready
// out_if  | out | verdict, mute_until                      | valid && ready
// cfg_if  | in  | index, data                              | valid && ready
//
// an item passes the steps slot read, elapsed time, refill multiply, update and write back, in that order
// the next item is taken once the previous one has left its update step
// after reset a sweep clears every slot of the memory; config writes are taken meanwhile
// a stalled result holds the item in its update step until the output register frees
module per_account_flood_limiter (
  input  logic             clk,
  input  logic             rst_n,
  pafl_in_if.sink          in_if,
  pafl_out_if.source       out_if,
  pafl_cfg_if.sink         cfg_if
);

  // configuration
  logic [7:0]  burst_r;
  logic [15:0] refill_r;
  logic [7:0]  drops_r;
  logic [15:0] mute_sec_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_r    <= pafl_pkg::BURST_RST;
      refill_r   <= pafl_pkg::REFILL_RST;
      drops_r    <= pafl_pkg::DROPS_RST;
      mute_sec_r <= pafl_pkg::MUTE_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        pafl_pkg::CFG_BURST:  burst_r    <= cfg_if.data[7:0];
        pafl_pkg::CFG_REFILL: refill_r   <= cfg_if.data;
        pafl_pkg::CFG_DROPS:  drops_r    <= cfg_if.data[7:0];
        pafl_pkg::CFG_MUTE:   mute_sec_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // store
  pafl_pkg::store_req_t st_req;
  pafl_pkg::entry_t     st_rdata;
  logic                 st_busy;

  pafl_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (st_req),
    .rd_data (st_rdata),
    .busy    (st_busy)
  );

  // control
  pafl_pkg::state_t state_r;
  pafl_pkg::state_t state_nxt;
  logic             in_accept;
  logic             upd_done;
  logic             upd_write;

  logic out_valid_r;
  logic out_valid_nxt;
  logic [1:0]  out_verdict_r;
  logic [31:0] out_until_r;

  // item registers
  logic [pafl_pkg::SLOT_W-1:0] slot_r;
  logic                        zero_r;
  logic [pafl_pkg::SEC_W-1:0]  sec_r;
  logic [pafl_pkg::FRAC_W-1:0] frac_r;
  logic [pafl_pkg::TOK_W-1:0]  tok_r;
  logic [pafl_pkg::DROP_W-1:0] drop_r;
  logic [pafl_pkg::EL_W-1:0]   el_r;
  logic                        hold_r;
  logic [pafl_pkg::SEC_W-1:0]  dl_r;
  logic [pafl_pkg::PROD_W-1:0] prod_r;

  assign in_accept = in_if.valid && in_if.ready;
  assign upd_done  = !out_valid_r || out_if.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pafl_pkg::ST_CLEAR: if (!st_busy) state_nxt = pafl_pkg::ST_IDLE;
      pafl_pkg::ST_IDLE:  if (in_accept) state_nxt = pafl_pkg::ST_CALC;
      pafl_pkg::ST_CALC:  state_nxt = pafl_pkg::ST_MUL;
      pafl_pkg::ST_MUL:   state_nxt = pafl_pkg::ST_UPD;
      pafl_pkg::ST_UPD:   if (upd_done) state_nxt = pafl_pkg::ST_IDLE;
      default:            state_nxt = pafl_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pafl_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // elapsed time step
  logic [pafl_pkg::TIME_W-1:0] now_t;
  logic [pafl_pkg::TOK_W-1:0]  cap;
  logic [pafl_pkg::TIME_W-1:0] c_last;
  logic [pafl_pkg::TOK_W-1:0]  c_tok;
  logic [pafl_pkg::DROP_W-1:0] c_drop;
  logic [pafl_pkg::SEC_W-1:0]  c_dl;
  logic                        c_hold;
  logic [pafl_pkg::TIME_W-1:0] c_diff;
  logic [pafl_pkg::EL_W-1:0]   c_el;

  assign now_t = {sec_r, frac_r};
  assign cap   = {burst_r, 16'h0000};

  always_comb begin
    if (!st_rdata.seen) begin
      c_last = now_t;
      c_tok  = cap;
      c_drop = '0;
      c_dl   = '0;
    end else begin
      c_last = st_rdata.last_time;
      c_tok  = st_rdata.tokens;
      c_drop = st_rdata.drop_run;
      c_dl   = st_rdata.deadline;
    end
    c_hold = (c_dl != '0) && (sec_r < c_dl);
    if ((c_dl != '0) && !c_hold) begin
      // served mute: full bucket again
      c_last = now_t;
      c_tok  = cap;
      c_drop = '0;
    end
    c_diff = now_t - c_last;
    if (now_t > c_last) begin
      c_el = (|c_diff[pafl_pkg::TIME_W-1:pafl_pkg::EL_W]) ? '1 : c_diff[pafl_pkg::EL_W-1:0];
    end else begin
      c_el = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      slot_r <= pafl_pkg::SLOT_W'(in_if.account_slot);
      zero_r <= (in_if.account_slot == '0) ||
                (32'(in_if.account_slot) >= 32'(pafl_pkg::SLOTS));
      sec_r  <= in_if.now_seconds;
      frac_r <= in_if.now_fraction;
    end
    if (state_r == pafl_pkg::ST_CALC) begin
      tok_r  <= c_tok;
      drop_r <= c_drop;
      el_r   <= c_el;
      hold_r <= c_hold;
      dl_r   <= c_dl;
    end
    if (state_r == pafl_pkg::ST_MUL) begin
      prod_r <= pafl_pkg::PROD_W'(el_r) * pafl_pkg::PROD_W'(refill_r);
    end
  end

  // update step
  logic [pafl_pkg::PROD_W:0]   u_level;
  logic [pafl_pkg::TOK_W-1:0]  u_capped;
  logic                        u_allow;
  logic [pafl_pkg::DROP_W-1:0] u_drop_inc;
  logic                        u_mute;
  logic [pafl_pkg::SEC_W:0]    u_sum;
  logic [pafl_pkg::SEC_W-1:0]  u_until;
  pafl_pkg::entry_t            u_entry;
  pafl_pkg::verdict_t          u_verdict;
  logic [pafl_pkg::SEC_W-1:0]  u_mute_until;

  always_comb begin
    u_level    = (pafl_pkg::PROD_W + 1)'(tok_r) + (pafl_pkg::PROD_W + 1)'(prod_r);
    u_capped   = (u_level > (pafl_pkg::PROD_W + 1)'(cap)) ? cap
                                                          : u_level[pafl_pkg::TOK_W-1:0];
    u_allow    = |u_capped[pafl_pkg::TOK_W-1:pafl_pkg::FRACT_TOK_W];
    u_drop_inc = (drop_r == '1) ? drop_r : drop_r + 1'b1;
    u_mute     = u_drop_inc >= drops_r;
    u_sum      = (pafl_pkg::SEC_W + 1)'(sec_r) + (pafl_pkg::SEC_W + 1)'(mute_sec_r);
    u_until    = u_sum[pafl_pkg::SEC_W] ? '1 : u_sum[pafl_pkg::SEC_W-1:0];

    u_entry.seen      = 1'b1;
    u_entry.last_time = now_t;
    u_entry.tokens    = u_capped;
    u_entry.drop_run  = u_drop_inc;
    u_entry.deadline  = '0;
    upd_write         = 1'b1;
    u_mute_until      = '0;

    priority if (zero_r) begin
      u_verdict = pafl_pkg::V_ALLOW;
      upd_write = 1'b0;
    end else if (hold_r) begin
      u_verdict    = pafl_pkg::V_MUTE;
      u_mute_until = dl_r;
      upd_write    = 1'b0;
    end else if (u_allow) begin
      u_verdict        = pafl_pkg::V_ALLOW;
      u_entry.tokens   = u_capped - pafl_pkg::TOK_W'(1 << pafl_pkg::FRACT_TOK_W);
      u_entry.drop_run = '0;
    end else if (u_mute) begin
      u_verdict        = pafl_pkg::V_MUTE;
      u_entry.deadline = u_until;
      u_mute_until     = u_until;
    end else begin
      u_verdict = pafl_pkg::V_DROP;
    end
  end

  // handshake and store controls
  always_comb begin
    in_if.ready     = (state_r == pafl_pkg::ST_IDLE);
    st_req.rd_en    = in_accept;
    st_req.rd_addr  = pafl_pkg::SLOT_W'(in_if.account_slot);
    st_req.wr_en    = (state_r == pafl_pkg::ST_UPD) && upd_done && upd_write;
    st_req.wr_addr  = slot_r;
    st_req.wr_data  = u_entry;
    out_valid_nxt   = out_valid_r && !out_if.ready;
    if ((state_r == pafl_pkg::ST_UPD) && upd_done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == pafl_pkg::ST_UPD) && upd_done) begin
      out_verdict_r <= u_verdict;
      out_until_r   <= u_mute_until;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.verdict    = out_verdict_r;
  assign out_if.mute_until = out_until_r;

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> !st_busy)
    else $error("item accepted during memory clear");

  a_write_in_update: assert property (@(posedge clk) disable iff (!rst_n)
    st_req.wr_en |-> (state_r == pafl_pkg::ST_UPD) && !st_busy)
    else $error("slot write outside update step");

  a_accept_to_calc: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == pafl_pkg::ST_CALC))
    else $error("accepted item did not enter calc step");

  a_non_mute_no_deadline: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_verdict_r != pafl_pkg::V_MUTE) |-> (out_until_r == '0))
    else $error("deadline reported without mute verdict");

endmodule

// File: verif/tb_per_account_flood_limiter.sv
// testbench for per_account_flood_limiter: directed and random traffic against a token bucket predictor
module tb_per_account_flood_limiter;
  timeunit 1ns;
  timeprecision 1ps;

  import pafl_pkg::*;

  localparam int PERIOD = 4;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 185;
  localparam int HOT_SLOTS = 6;
  localparam logic [63:0] ONE_TOKEN = 64'd65536;

  typedef struct {
    verdict_t          verdict;
    logic [SEC_W-1:0]  mute_until;
  } verdict_word_t;

  class flood_scoreboard;
    bit [7:0]            burst = BURST_RST;
    bit [RATE_W-1:0]     refill = REFILL_RST;
    bit [DROP_W-1:0]     drop_limit = DROPS_RST;
    bit [15:0]           mute_len = MUTE_RST;
    bit                  seen [SLOTS];
    bit [TIME_W-1:0]     stamp [SLOTS];
    bit [TOK_W-1:0]      bucket [SLOTS];
    bit [DROP_W-1:0]     run_len [SLOTS];
    bit [SEC_W-1:0]      deadline [SLOTS];
    verdict_word_t       verdicts_due [$];
    int                  errors;

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_BURST:  burst = value[7:0];
        CFG_REFILL: refill = value;
        CFG_DROPS:  drop_limit = value[7:0];
        CFG_MUTE:   mute_len = value;
        default: ;
      endcase
    endfunction

    function void note_request(logic [ACCT_W-1:0] slot, logic [SEC_W-1:0] sec,
                               logic [FRAC_W-1:0] frac);
      logic [TIME_W-1:0] now;
      logic [63:0] cap, elapsed, level, sum;
      verdict_word_t w;
      now = {sec, frac};
      cap = 64'(burst) << FRACT_TOK_W;
      w.verdict = V_ALLOW;
      w.mute_until = '0;
      if (slot != 0) begin
        if (!seen[slot]) begin
          seen[slot] = 1'b1;
          stamp[slot] = now;
          bucket[slot] = cap[TOK_W-1:0];
          run_len[slot] = '0;
          deadline[slot] = '0;
        end
        if (deadline[slot] != 0 && sec < deadline[slot]) begin
          w.verdict = V_MUTE;
          w.mute_until = deadline[slot];
        end else begin
          if (deadline[slot] != 0) begin
            deadline[slot] = '0;
            run_len[slot] = '0;
            bucket[slot] = cap[TOK_W-1:0];
            stamp[slot] = now;
          end
          elapsed = (now > stamp[slot]) ? 64'(now) - 64'(stamp[slot]) : 64'd0;
          stamp[slot] = now;
          level = 64'(bucket[slot]) + elapsed * 64'(refill);
          if (level > cap) level = cap;
          if (level >= ONE_TOKEN) begin
            bucket[slot] = TOK_W'(level - ONE_TOKEN);
            run_len[slot] = '0;
          end else begin
            bucket[slot] = level[TOK_W-1:0];
            if (run_len[slot] != 8'hFF) run_len[slot]++;
            if (run_len[slot] >= drop_limit) begin
              sum = 64'(sec) + 64'(mute_len);
              if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
              deadline[slot] = sum[SEC_W-1:0];
              w.verdict = V_MUTE;
              w.mute_until = deadline[slot];
            end else begin
              w.verdict = V_DROP;
            end
          end
        end
      end
      verdicts_due = {verdicts_due, w};
    endfunction

    task check_result(logic [1:0] verdict, logic [SEC_W-1:0] mute_until);
      verdict_word_t w;
      if (verdicts_due.size() == 0) begin
        report_mismatch($sformatf("result word with nothing pending: verdict %0d until %0d",
                                  verdict, mute_until));
      end else begin
        w = verdicts_due.pop_front();
        if (verdict !== w.verdict)
          report_mismatch($sformatf("verdict %0d, predicted %0d", verdict, w.verdict));
        if (mute_until !== w.mute_until)
          report_mismatch($sformatf("mute_until %0d, predicted %0d", mute_until,
                                    w.mute_until));
      end
    endtask

    function int pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycles;
  int   in_max_gap;
  int   out_max_stall;
  int   out_hold_req;
  logic [TIME_W-1:0] wall;
  logic [ACCT_W-1:0] hot [HOT_SLOTS];
  flood_scoreboard sb = new();

  pafl_in_if  in_ch ();
  pafl_out_if out_ch ();
  pafl_cfg_if cfg_ch ();

  per_account_flood_limiter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  always #(PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words pending", cycles, sb.pending());
      $display("tb_per_account_flood_limiter: FAIL");
      $finish;
    end
  end

  task automatic send_request(logic [ACCT_W-1:0] slot, logic [SEC_W-1:0] sec,
                              logic [FRAC_W-1:0] frac);
    int gap;
    gap = $urandom_range(0, in_max_gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.account_slot <= slot;
    in_ch.now_seconds  <= sec;
    in_ch.now_fraction <= frac;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(slot, sec, frac);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_reg(idx, value);
  endtask

  task automatic random_request();
    int pick;
    logic [ACCT_W-1:0] slot;
    pick = $urandom_range(0, 99);
    if (pick < 5) slot = '0;
    else if (pick < 15) slot = ACCT_W'($urandom_range(0, SLOTS - 1));
    else slot = hot[$urandom_range(0, HOT_SLOTS - 1)];
    pick = $urandom_range(0, 99);
    if (pick < 15) ;
    else if (pick < 75) wall += TIME_W'($urandom_range(1, 300));
    else if (pick < 87) wall += TIME_W'($urandom_range(1024, 20 * 1024));
    else if (pick < 95) wall += (TIME_W'(sb.mute_len) + TIME_W'($urandom_range(0, 2))) << 10;
    else wall -= TIME_W'($urandom_range(1, 3000));
    send_request(slot, wall[TIME_W-1:FRAC_W], wall[FRAC_W-1:0]);
  endtask

  // result side: per-word stall plus an occasional long hold-off
  initial begin
    int stall;
    forever begin
      stall = $urandom_range(0, out_max_stall);
      if (out_hold_req > 0) begin
        stall = out_hold_req;
        out_hold_req = 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      sb.check_result(out_ch.verdict, out_ch.mute_until);
    end
  end

  initial begin
    logic [7:0]  burst_v, drops_v;
    logic [15:0] refill_v, mute_v;
    clk = 1'b0;
    rst_n = 1'b0;
    cycles = 0;
    in_max_gap = 4;
    out_max_stall = 4;
    out_hold_req = 0;
    in_ch.valid = 1'b0;
    in_ch.account_slot = '0;
    in_ch.now_seconds = '0;
    in_ch.now_fraction = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_BURST;
    cfg_ch.data = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: slot zero, fill and empty a bucket, mute, served mute, time backwards
    send_request('0, '1, '1);
    repeat (10) send_request(10'd1023, 32'd100, 10'd0);
    send_request(10'd1023, 32'd120, 10'd512);
    send_request(10'd1023, 32'd160, 10'd0);
    send_request(10'd1023, 32'd150, 10'd1023);
    // deadline saturates near the top of the seconds range
    repeat (10) send_request(10'd2, 32'hFFFF_FFF0, 10'd1023);
    send_request(10'd2, 32'hFFFF_FFFF, 10'd0);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: begin
          burst_v = 8'd1; refill_v = 16'd0; drops_v = 8'd1; mute_v = 16'd1;
        end
        1: begin
          burst_v = 8'd255; refill_v = 16'hFFFF; drops_v = 8'd255; mute_v = 16'hFFFF;
        end
        2: begin
          burst_v = 8'($urandom_range(1, 255));
          refill_v = 16'($urandom_range(0, 65535));
          drops_v = 8'($urandom_range(1, 255));
          mute_v = 16'($urandom_range(1, 65535));
        end
        PHASES - 1: begin
          burst_v = BURST_RST; refill_v = REFILL_RST; drops_v = DROPS_RST; mute_v = MUTE_RST;
        end
        default: begin
          burst_v = 8'($urandom_range(1, 8));
          refill_v = 16'($urandom_range(0, 400));
          drops_v = 8'($urandom_range(1, 6));
          mute_v = 16'($urandom_range(1, 30));
        end
      endcase
      write_reg(CFG_BURST, 16'(burst_v));
      write_reg(CFG_REFILL, refill_v);
      write_reg(CFG_DROPS, 16'(drops_v));
      write_reg(CFG_MUTE, mute_v);
      cfg_ch.valid <= 1'b0;

      wall = {SEC_W'($urandom), FRAC_W'($urandom_range(0, 1023))};
      if (phase == 3) wall[TIME_W-1:FRAC_W] = 32'hFFFF_FF00;
      foreach (hot[k]) hot[k] = ACCT_W'($urandom_range(1, SLOTS - 1));

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        in_max_gap = (phase == 4 || (i >= 120 && i < 150)) ? 0 : 4;
        out_max_stall = (phase == 4 || (i >= 120 && i < 150)) ? 0 : 4;
        if ((phase == 2 || phase == 5) && i == 60) out_hold_req = 300;
        if (phase == 6 && i == 90) drain();
        random_request();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.pending() > 0)
      sb.report_mismatch($sformatf("%0d predicted words never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("tb_per_account_flood_limiter: PASS");
    end else begin
      $display("tb_per_account_flood_limiter: FAIL");
    end
    $finish;
  end

endmodule
